@@ hw/rtl/atts_pkg.sv @@
// Package for the ANSI text terminal stream core: byte codes, parser phases,
// queue entry type and the color palette. No dependencies.
`default_nettype none
package atts_pkg;

  localparam int unsigned ArgLimit = 16;
  localparam int unsigned QDepth   = 2;

  localparam logic [7:0] ByteEsc  = 8'h1B;
  localparam logic [7:0] ByteNl   = 8'h0A;
  localparam logic [7:0] ByteBs   = 8'h08;
  localparam logic [7:0] ByteLbr  = 8'h5B;
  localparam logic [7:0] ByteSemi = 8'h3B;
  localparam logic [7:0] ByteH    = 8'h48;
  localparam logic [7:0] ByteM    = 8'h6D;
  localparam logic [7:0] ByteSpc  = 8'h20;

  localparam logic CfgColumns = 1'b0;
  localparam logic CfgRows    = 1'b1;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhEsc  = 2'd1,
    PhCsi  = 2'd2,
    PhSkip = 2'd3
  } phase_e;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OpNone,
    OpNewline,
    OpBackspace,
    OpPrint,
    OpHome,
    OpColor
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] glyph;
    logic [2:0] fg;
    logic [2:0] bg;
  } cmd_t;

  function automatic logic [23:0] palette(input logic [2:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      3'd0: rgb = 24'h1E1E2E;
      3'd1: rgb = 24'hF38BA8;
      3'd2: rgb = 24'hA6E3A1;
      3'd3: rgb = 24'hF9E2AF;
      3'd4: rgb = 24'h89B4FA;
      3'd5: rgb = 24'hCBA6F7;
      3'd6: rgb = 24'h94E2D5;
      default: rgb = 24'hCDD6F4;
    endcase
    return rgb;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/atts_byte_if.sv @@
// Valid/ready channel carrying one stream byte.
// Depends on nothing.
`default_nettype none
interface atts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/atts_cmd_if.sv @@
// Valid/ready channel carrying one terminal command.
// Depends on nothing.
`default_nettype none
interface atts_cmd_if;
  logic        valid;
  logic        ready;
  logic        draw;
  logic        scroll;
  logic [7:0]  column;
  logic [6:0]  row;
  logic [7:0]  glyph;
  logic [23:0] fg_rgb;
  logic [23:0] bg_rgb;
  modport source (output valid, output draw, output scroll, output column, output row,
                  output glyph, output fg_rgb, output bg_rgb, input ready);
  modport sink   (input valid, input draw, input scroll, input column, input row,
                  input glyph, input fg_rgb, input bg_rgb, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/atts_front.sv @@
// Front end: escape parser and SGR evaluation; emits classified commands.
// Depends on atts_pkg.
`default_nettype none
module atts_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [7:0]     in_byte_i,
  output logic                in_ready_o,
  output logic                cmd_valid_o,
  output atts_pkg::cmd_t      cmd_o,
  input  wire logic           cmd_ready_i
);

  atts_pkg::phase_e phase_q, phase_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] val_q, val_d;
  logic [2:0] pfg_q, pfg_d, pbg_q, pbg_d;
  logic [2:0] fg_q, fg_d, bg_q, bg_d;
  logic       letter, digit, take;
  logic [2:0] sfg, sbg;
  logic [11:0] mul;

  assign in_ready_o = cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign letter = (in_byte_i >= 8'h41 && in_byte_i <= 8'h5A) ||
                  (in_byte_i >= 8'h61 && in_byte_i <= 8'h7A);
  assign digit  = in_byte_i >= 8'h30 && in_byte_i <= 8'h39;
  assign mul    = {4'd0, val_q} * 12'd10 + {8'd0, in_byte_i[3:0]};

  // Apply the current argument to the pending colors
  always_comb begin
    sfg = pfg_q;
    sbg = pbg_q;
    if (val_q == 8'd0) begin
      sfg = 3'd7;
      sbg = 3'd0;
    end else if (val_q >= 8'd30 && val_q <= 8'd37) begin
      sfg = 3'(val_q - 8'd30);
    end else if (val_q >= 8'd40 && val_q <= 8'd47) begin
      sbg = 3'(val_q - 8'd40);
    end
  end

  // Parse the byte and classify it
  always_comb begin
    phase_d = phase_q;
    idx_d = idx_q;
    val_d = val_q;
    pfg_d = pfg_q;
    pbg_d = pbg_q;
    fg_d = fg_q;
    bg_d = bg_q;
    cmd_valid_o = 1'b0;
    cmd_o.op = atts_pkg::OpNone;
    cmd_o.glyph = in_byte_i;
    cmd_o.fg = fg_q;
    cmd_o.bg = bg_q;
    if (in_byte_i == atts_pkg::ByteEsc) begin
      phase_d = atts_pkg::PhEsc;
      idx_d = '0;
      val_d = '0;
      pfg_d = fg_q;
      pbg_d = bg_q;
    end else begin
      unique case (phase_q)
        atts_pkg::PhEsc: begin
          if (in_byte_i == atts_pkg::ByteLbr) phase_d = atts_pkg::PhCsi;
          else if (letter) phase_d = atts_pkg::PhIdle;
          else phase_d = atts_pkg::PhSkip;
        end
        atts_pkg::PhSkip: begin
          if (letter) phase_d = atts_pkg::PhIdle;
        end
        atts_pkg::PhCsi: begin
          if (letter) begin
            phase_d = atts_pkg::PhIdle;
            if (in_byte_i == atts_pkg::ByteH) begin
              cmd_valid_o = 1'b1;
              cmd_o.op = atts_pkg::OpHome;
            end else if (in_byte_i == atts_pkg::ByteM) begin
              fg_d = sfg;
              bg_d = sbg;
              cmd_valid_o = 1'b1;
              cmd_o.op = atts_pkg::OpColor;
              cmd_o.fg = sfg;
              cmd_o.bg = sbg;
            end
          end else if (in_byte_i == atts_pkg::ByteSemi) begin
            if (idx_q >= 4'(atts_pkg::ArgLimit - 1)) begin
              phase_d = atts_pkg::PhSkip;
            end else begin
              pfg_d = sfg;
              pbg_d = sbg;
              val_d = '0;
              idx_d = idx_q + 4'd1;
            end
          end else if (digit) begin
            val_d = (mul > 12'd255) ? 8'd255 : mul[7:0];
          end
        end
        default: begin
          cmd_valid_o = 1'b1;
          if (in_byte_i == atts_pkg::ByteNl) cmd_o.op = atts_pkg::OpNewline;
          else if (in_byte_i == atts_pkg::ByteBs) cmd_o.op = atts_pkg::OpBackspace;
          else cmd_o.op = atts_pkg::OpPrint;
        end
      endcase
    end
    cmd_valid_o = cmd_valid_o && in_valid_i;
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= atts_pkg::PhIdle;
      idx_q <= '0;
      val_q <= '0;
      pfg_q <= 3'd7;
      pbg_q <= 3'd0;
      fg_q <= 3'd7;
      bg_q <= 3'd0;
    end else if (take) begin
      phase_q <= phase_d;
      idx_q <= idx_d;
      val_q <= val_d;
      pfg_q <= pfg_d;
      pbg_q <= pbg_d;
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> in_valid_i) else $error("command without input");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_byte_i == atts_pkg::ByteEsc) |=> phase_q == atts_pkg::PhEsc)
    else $error("ESC did not start a sequence");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && cmd_o.op == atts_pkg::OpPrint) |-> phase_q == atts_pkg::PhIdle)
    else $error("glyph printed inside a sequence");

endmodule
`default_nettype wire

@@ hw/rtl/atts_queue.sv @@
// Two-entry command queue between front and back end.
// Depends on atts_pkg.
`default_nettype none
module atts_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  input  wire atts_pkg::cmd_t wr_data_i,
  output logic                wr_ready_o,
  output logic                rd_valid_o,
  output atts_pkg::cmd_t      rd_data_o,
  input  wire logic           rd_ready_i
);

  atts_pkg::cmd_t mem_q [atts_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = cnt_q != 2'(atts_pkg::QDepth);
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(atts_pkg::QDepth)) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wp_q == rp_q)) else $error("pointers diverged");

endmodule
`default_nettype wire

@@ hw/rtl/atts_back.sv @@
// Back end: cursor movement, wrap and scroll; registered result output.
// Depends on atts_pkg.
`default_nettype none
module atts_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_idx_i,
  input  wire logic [8:0]     cfg_data_i,
  input  wire logic           cmd_valid_i,
  input  wire atts_pkg::cmd_t cmd_i,
  output logic                cmd_ready_o,
  output logic                out_valid_o,
  output logic                draw_o,
  output logic                scroll_o,
  output logic [7:0]          column_o,
  output logic [6:0]          row_o,
  output logic [7:0]          glyph_o,
  output logic [23:0]         fg_rgb_o,
  output logic [23:0]         bg_rgb_o,
  input  wire logic           out_ready_i
);

  logic [8:0] cols_q;
  logic [7:0] rows_q;
  logic [7:0] col_q, col_d;
  logic [6:0] row_q, row_d;
  logic [2:0] fg_q, fg_d, bg_q, bg_d;
  logic       ov_q;
  logic       emit, dr, sc;
  logic [7:0] ocol, ogl;
  logic [6:0] orow;
  logic [8:0] clim;
  logic [7:0] rlim;
  logic       take, nl_scroll;

  assign clim = (cols_q > 9'd256) ? 9'd256 : cols_q;
  assign rlim = (rows_q > 8'd128) ? 8'd128 : rows_q;
  assign nl_scroll = ({1'b0, row_q} + 8'd1) >= rlim;
  assign cmd_ready_o = !ov_q || out_ready_i;
  assign take = cmd_valid_i && cmd_ready_o;

  // Execute one command
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    fg_d = fg_q;
    bg_d = bg_q;
    emit = 1'b0;
    dr = 1'b0;
    sc = 1'b0;
    ocol = '0;
    orow = '0;
    ogl = '0;
    unique case (cmd_i.op)
      atts_pkg::OpNewline: begin
        col_d = '0;
        if (nl_scroll) begin
          emit = 1'b1;
          sc = 1'b1;
        end else begin
          row_d = row_q + 7'd1;
        end
      end
      atts_pkg::OpBackspace: begin
        if (col_q != 8'd0) col_d = col_q - 8'd1;
        emit = 1'b1;
        dr = 1'b1;
        ocol = col_d;
        orow = row_q;
        ogl = atts_pkg::ByteSpc;
      end
      atts_pkg::OpPrint: begin
        emit = 1'b1;
        dr = 1'b1;
        ocol = col_q;
        orow = row_q;
        ogl = cmd_i.glyph;
        if (({1'b0, col_q} + 9'd1) >= clim) begin
          col_d = '0;
          if (nl_scroll) sc = 1'b1;
          else row_d = row_q + 7'd1;
        end else begin
          col_d = col_q + 8'd1;
        end
      end
      atts_pkg::OpHome: begin
        col_d = '0;
        row_d = '0;
      end
      atts_pkg::OpColor: begin
        fg_d = cmd_i.fg;
        bg_d = cmd_i.bg;
      end
      default: ;
    endcase
  end

  // Hold cursor, colors and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 9'd80;
      rows_q <= 8'd25;
      col_q <= '0;
      row_q <= '0;
      fg_q <= 3'd7;
      bg_q <= 3'd0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == atts_pkg::CfgColumns) cols_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == atts_pkg::CfgRows) rows_q <= cfg_data_i[7:0];
      if (take) begin
        col_q <= col_d;
        row_q <= row_d;
        fg_q <= fg_d;
        bg_q <= bg_d;
      end
      if (take) ov_q <= emit;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      draw_o <= dr;
      scroll_o <= sc;
      column_o <= ocol;
      row_o <= orow;
      glyph_o <= ogl;
      fg_rgb_o <= atts_pkg::palette(fg_q);
      bg_rgb_o <= atts_pkg::palette(bg_q);
    end
  end

  assign out_valid_o = ov_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd_ready_o) else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o) |-> (draw_o || scroll_o)) else $error("empty result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cmd_i.op == atts_pkg::OpHome) |=> (col_q == 8'd0 && row_q == 7'd0))
    else $error("home failed");

endmodule
`default_nettype wire

@@ hw/rtl/ansi_text_terminal_stream_core.sv @@
// Top level of the ANSI text terminal stream core.
// Depends on atts_pkg, atts_byte_if, atts_cmd_if, atts_front, atts_queue, atts_back.
//
// One byte is accepted per cycle while the queue has room. The front end
// classifies the byte into the two-entry queue at the edge that accepts it.
// The back end takes the oldest queued command, executes it and loads the
// output register, from which the result is taken. The sustained rate is one
// byte per cycle while results are taken. A stalled result holds the back
// end, and the input stalls once the queue is full.
// Configuration: cfg_we_i with cfg_idx_i 0 = columns, 1 = rows.
`default_nettype none
module ansi_text_terminal_stream_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [8:0] cfg_data_i,
  atts_byte_if.sink       in_if,
  atts_cmd_if.source      out_if
);

  logic           f_valid, f_ready, q_valid, q_ready;
  atts_pkg::cmd_t f_cmd, q_cmd;

  atts_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_byte_i(in_if.byte_in), .in_ready_o(in_if.ready),
    .cmd_valid_o(f_valid), .cmd_o(f_cmd), .cmd_ready_i(f_ready)
  );

  atts_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_data_i(f_cmd), .wr_ready_o(f_ready),
    .rd_valid_o(q_valid), .rd_data_o(q_cmd), .rd_ready_i(q_ready)
  );

  atts_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_valid_i(q_valid), .cmd_i(q_cmd), .cmd_ready_o(q_ready),
    .out_valid_o(out_if.valid), .draw_o(out_if.draw), .scroll_o(out_if.scroll),
    .column_o(out_if.column), .row_o(out_if.row), .glyph_o(out_if.glyph),
    .fg_rgb_o(out_if.fg_rgb), .bg_rgb_o(out_if.bg_rgb), .out_ready_i(out_if.ready)
  );

endmodule
`default_nettype wire

@@ verif/atts_tb_if.sv @@
// Testbench-side channel definitions are taken from the RTL interfaces;
// this file holds the shared command and stimulus helper types. Depends on atts_pkg.
`timescale 1ns / 100ps
`default_nettype none
package atts_tb_pkg;
  import atts_pkg::*;

  typedef struct packed {
    logic        draw;
    logic        scroll;
    logic [7:0]  column;
    logic [6:0]  row;
    logic [7:0]  glyph;
    logic [23:0] fg_rgb;
    logic [23:0] bg_rgb;
  } term_cmd_t;

  // Request to the driver: either a byte or a register write
  typedef struct packed {
    logic       is_cfg;
    logic       cfg_idx;
    logic [8:0] cfg_data;
    logic [7:0] data;
  } stim_t;
endpackage
`default_nettype wire

@@ verif/ansi_text_terminal_stream_core_tb.sv @@
// Testbench for ansi_text_terminal_stream_core: drives byte streams with
// random idling, predicts terminal commands and compares them field by field.
// Depends on atts_pkg, atts_tb_pkg, atts_byte_if, atts_cmd_if and the core.
`timescale 1ns / 100ps
`default_nettype none
module ansi_text_terminal_stream_core_tb;
  import atts_pkg::*;
  import atts_tb_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [8:0] cfg_data_i = '0;

  atts_byte_if in_if ();
  atts_cmd_if  out_if ();

  ansi_text_terminal_stream_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic [8:0] ncols;
  logic [7:0] nrows;
  phase_e     ph;
  logic [3:0] arg_idx;
  logic [7:0] arg_val;
  logic [2:0] pend_fg, pend_bg, cur_fg, cur_bg;
  logic [7:0] cur_col;
  logic [6:0] cur_row;

  term_cmd_t cmd_q[$];
  stim_t     req_q[$];
  int        fails = 0;
  int        cycles = 0;
  int        queued = 0;
  bit        calm = 1'b0;
  logic      in_took = 1'b0;
  int        in_gap = 0, out_gap = 0;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic void take_sgr(logic [7:0] v);
    if (v == 0) begin
      pend_fg = 3'd7;
      pend_bg = 3'd0;
    end else if (v >= 30 && v <= 37) begin
      pend_fg = 3'(v - 30);
    end else if (v >= 40 && v <= 47) begin
      pend_bg = 3'(v - 40);
    end
  endfunction

  // Advance to next row; return 1 when the screen must scroll
  function automatic bit line_feed();
    int lim;
    lim = (nrows > 128) ? 128 : nrows;
    cur_col = '0;
    if (int'(cur_row) + 1 >= lim) return 1'b1;
    cur_row = cur_row + 7'd1;
    return 1'b0;
  endfunction

  function automatic void push_cmd(bit dr, bit sc, logic [7:0] col, logic [6:0] row,
                                   logic [7:0] gl);
    term_cmd_t t;
    t.draw = dr; t.scroll = sc; t.column = col; t.row = row; t.glyph = gl;
    t.fg_rgb = palette(cur_fg);
    t.bg_rgb = palette(cur_bg);
    cmd_q.push_back(t);
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    int v, lim;
    logic [7:0] col;
    logic [6:0] row;
    bit sc;
    if (c == ByteEsc) begin
      ph = PhEsc; arg_idx = '0; arg_val = '0;
      pend_fg = cur_fg; pend_bg = cur_bg;
      return;
    end
    case (ph)
      PhEsc: begin
        if (c == ByteLbr) ph = PhCsi;
        else if (is_letter(c)) ph = PhIdle;
        else ph = PhSkip;
        return;
      end
      PhSkip: begin
        if (is_letter(c)) ph = PhIdle;
        return;
      end
      PhCsi: begin
        if (is_letter(c)) begin
          ph = PhIdle;
          if (c == ByteH) begin
            cur_col = '0; cur_row = '0;
          end else if (c == ByteM) begin
            take_sgr(arg_val);
            cur_fg = pend_fg; cur_bg = pend_bg;
          end
        end else if (c == ByteSemi) begin
          if (arg_idx >= ArgLimit - 1) ph = PhSkip;
          else begin
            take_sgr(arg_val);
            arg_val = '0;
            arg_idx = arg_idx + 4'd1;
          end
        end else if (c >= 8'h30 && c <= 8'h39) begin
          v = int'(arg_val) * 10 + int'(c - 8'h30);
          arg_val = (v > 255) ? 8'd255 : 8'(v);
        end
        return;
      end
      default: ;
    endcase
    if (c == ByteNl) begin
      if (line_feed()) push_cmd(1'b0, 1'b1, '0, '0, '0);
      return;
    end
    if (c == ByteBs) begin
      if (cur_col > 0) cur_col = cur_col - 8'd1;
      push_cmd(1'b1, 1'b0, cur_col, cur_row, ByteSpc);
      return;
    end
    col = cur_col; row = cur_row;
    lim = (ncols > 256) ? 256 : ncols;
    sc = 1'b0;
    if (int'(cur_col) + 1 >= lim) sc = line_feed();
    else cur_col = cur_col + 8'd1;
    push_cmd(1'b1, sc, col, row, c);
  endfunction

  // Queue helpers for the stimulus
  task automatic add_byte(logic [7:0] b);
    stim_t s;
    s = '0; s.data = b;
    req_q.push_back(s);
    queued++;
  endtask

  task automatic add_str(string str);
    for (int i = 0; i < str.len(); i++) add_byte(str[i]);
  endtask

  task automatic add_sgr_seq();
    int n;
    n = $urandom_range(0, 18);
    add_byte(ByteEsc);
    add_byte(ByteLbr);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: add_str($sformatf("%0d", $urandom_range(30, 37)));
        1: add_str($sformatf("%0d", $urandom_range(40, 47)));
        2: add_str("0");
        3: add_str($sformatf("%0d", $urandom_range(0, 999)));
        default: ;
      endcase
      if (i != n - 1) add_byte(ByteSemi);
    end
    add_byte(($urandom_range(0, 5) == 0) ? ByteH : ByteM);
  endtask

  // Wait for drain, then write a register while the core is idle
  task automatic write_cfg(logic idx, logic [8:0] val);
    while (req_q.size() != 0 || cmd_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgColumns) ncols = val;
    else nrows = val[7:0];
  endtask

  // Queue about count bytes of random traffic
  task automatic random_phase(int count);
    int start;
    start = queued;
    while (queued - start < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_sgr_seq();
        3: add_byte(ByteNl);
        4: add_byte(ByteBs);
        5: add_byte(8'($urandom_range(0, 255)));
        6: begin
          add_byte(ByteEsc);
          add_byte(8'($urandom_range(0, 255)));
          add_byte(8'($urandom_range(0, 255)));
        end
        default: add_byte(8'($urandom_range(32, 126)));
      endcase
    end
  endtask

  // Driver: present bytes at the falling edge, idle in bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_took) begin
        void'(req_q.pop_front());
        if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 12);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.byte_in <= req_q[0].data;
      end else begin
        in_if.valid <= 1'b0;
      end
      // Stall the command side in bursts
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 12);
      end
    end
  end

  // Monitor: compare each accepted command with the oldest prediction,
  // then predict the request accepted at this edge
  always @(posedge clk_i) begin
    term_cmd_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (cmd_q.size() == 0) begin
        $error("unexpected command draw=%0b scroll=%0b", out_if.draw, out_if.scroll);
        fails++;
      end else begin
        e = cmd_q.pop_front();
        if (out_if.draw !== e.draw) begin
          $error("draw exp %0h got %0h", e.draw, out_if.draw); fails++;
        end
        if (out_if.scroll !== e.scroll) begin
          $error("scroll exp %0h got %0h", e.scroll, out_if.scroll); fails++;
        end
        if (out_if.column !== e.column) begin
          $error("column exp %0h got %0h", e.column, out_if.column); fails++;
        end
        if (out_if.row !== e.row) begin
          $error("row exp %0h got %0h", e.row, out_if.row); fails++;
        end
        if (out_if.glyph !== e.glyph) begin
          $error("glyph exp %0h got %0h", e.glyph, out_if.glyph); fails++;
        end
        if (out_if.fg_rgb !== e.fg_rgb) begin
          $error("fg_rgb exp %0h got %0h", e.fg_rgb, out_if.fg_rgb); fails++;
        end
        if (out_if.bg_rgb !== e.bg_rgb) begin
          $error("bg_rgb exp %0h got %0h", e.bg_rgb, out_if.bg_rgb); fails++;
        end
      end
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      predict_byte(in_if.byte_in);
      in_took <= 1'b1;
    end else begin
      in_took <= 1'b0;
    end
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.byte_in = '0;
    out_if.ready = 1'b0;
    ncols = 9'd80; nrows = 8'd25; ph = PhIdle;
    arg_idx = '0; arg_val = '0;
    pend_fg = 3'd7; pend_bg = 3'd0; cur_fg = 3'd7; cur_bg = 3'd0;
    cur_col = '0; cur_row = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: printing, control bytes, sequences, overflow, skip paths
    add_byte(8'h00); add_byte(8'hFF); add_byte(8'h0D); add_byte(8'h80);
    add_byte(ByteBs); add_byte(ByteNl);
    add_str("\033[31;44m"); add_byte(8'h41);
    add_str("\033[m"); add_str("\033[999;32m");
    add_str("\033X"); add_str("\033(5;A"); add_str("\033[3\033[41m");
    add_str("\033[1;2;3;4;5;6;7;8;9;0;1;2;3;4;5;36;m"); add_str("\033[9H");
    add_str("\033[0;47;x\001z"); add_byte(8'h7F);

    // Extreme screens: single cell, zero, oversize, maximum
    write_cfg(CfgColumns, 9'd1); write_cfg(CfgRows, 8'd1);
    add_str("ab\n\010"); random_phase(40);
    write_cfg(CfgColumns, 9'd0); write_cfg(CfgRows, 8'd0);
    random_phase(40);
    write_cfg(CfgColumns, 9'h1FF); write_cfg(CfgRows, 8'hFF);
    random_phase(150);
    write_cfg(CfgColumns, 9'd256); write_cfg(CfgRows, 8'd128);
    random_phase(150);
    // Shrink the screen under the cursor
    write_cfg(CfgColumns, 9'd3); write_cfg(CfgRows, 8'd2);
    random_phase(150);
    write_cfg(CfgColumns, 9'($urandom_range(1, 511)));
    write_cfg(CfgRows, 8'($urandom_range(1, 255)));
    random_phase(300);
    write_cfg(CfgColumns, 9'd80); write_cfg(CfgRows, 8'd25);
    random_phase(200);
    while (req_q.size() > 60) @(posedge clk_i);
    calm = 1'b1;
    random_phase(100);

    while (req_q.size() != 0 || cmd_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/atts_pkg.sv
hw/rtl/atts_byte_if.sv
hw/rtl/atts_cmd_if.sv
hw/rtl/atts_front.sv
hw/rtl/atts_queue.sv
hw/rtl/atts_back.sv
hw/rtl/ansi_text_terminal_stream_core.sv
verif/atts_tb_if.sv
verif/ansi_text_terminal_stream_core_tb.sv
